// ----- rtl/gplm_pkg.sv -----
`default_nettype none

package gplm_pkg;

  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TOL_W-1:0]   TOLERANCE_RST = TOL_W'(2000);
  localparam logic [LIMIT_W-1:0] LIMIT_RST     = LIMIT_W'(5);
  localparam logic [CNT_W-1:0]   CNT_MAX       = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = CFG_IDX_W'(1);

  localparam logic ACT_PRESS  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [MODE_W-1:0] MODE_UNSET    = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_REC      = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LOCKED   = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_CHECK    = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_UNLOCKED = MODE_W'(4);

  typedef enum logic [4:0] {
    ST_UNSET    = 5'b00001,
    ST_REC      = 5'b00010,
    ST_LOCKED   = 5'b00100,
    ST_CHECK    = 5'b01000,
    ST_UNLOCKED = 5'b10000
  } lock_state_t;

  typedef struct packed {
    logic              action;
    logic [AXIS_W-1:0] axis_x;
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_z;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  sample_count;
    logic [CNT_W-1:0]  mismatch_total;
    logic              attempt_done;
    logic              attempt_passed;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/gesture_pattern_lock_matcher.sv -----
// Gesture pattern lock matcher.
// in_*  : one request per press or gyro sample (in_data.action 0 = press, 1 = sample).
// out_* : exactly one result per accepted request, in order: mode, sample count,
//         mismatch total and the attempt verdict flags.
// cfg_* : register writes (index 0 tolerance, index 1 mismatch limit); cfg_ready
//         is always high. Write only while no request is in flight.
// Output: a result is registered into the output register if free, else into
//         the skid entry. Throughput: one request per cycle unless in_stall;
//         the three axis lanes compare against the stored pattern entry in the
//         accept cycle, the entry prefetched from the pattern RAM the cycle before.
// Stall: an output register plus one skid entry hold results; in_stall rises
//         only when both are full, and is a registered signal.
// Reset: rst_n (sync, active low) returns to the unset mode, clears counters,
//         restores tolerance 2000 and limit 5, and empties the output stages.
//         Pattern RAM contents are not cleared; a check always follows a full
//         recording so no unwritten entry is used.
`default_nettype none

module gesture_pattern_lock_matcher #(
  parameter int unsigned PATTERN_LEN = 30,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire gplm_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output gplm_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gplm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gplm_pkg::TOL_W-1:0]        cfg_wdata
);

  localparam int unsigned IW = $clog2(PATTERN_LEN + 1);
  localparam int unsigned AW = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
  localparam int unsigned PW = 3 * SAMPLE_BITS;
  localparam logic [IW-1:0] LEN = IW'(PATTERN_LEN);

  gplm_pkg::lock_state_t state_r, state_nxt;
  logic [IW-1:0]                    idx_r, idx_nxt;
  logic [gplm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             failed_r, failed_nxt;
  logic [gplm_pkg::TOL_W-1:0]       tol_r, tol_nxt;
  logic [gplm_pkg::LIMIT_W-1:0]     limit_r, limit_nxt;

  logic                             out_valid_r, out_valid_nxt;
  gplm_pkg::out_item_t              out_data_r, out_data_nxt;
  logic                             skid_valid_r, skid_valid_nxt;
  gplm_pkg::out_item_t              skid_data_r, skid_data_nxt;

  logic                             in_fire;
  logic                             out_free;
  logic                             is_sample;
  logic                             idx_in_range;
  logic [IW-1:0]                    idx_inc;
  logic [gplm_pkg::CNT_W-1:0]       cnt_inc;
  logic [SAMPLE_BITS-1:0]           s_x, s_y, s_z;
  logic [PW-1:0]                    stored;
  logic [2:0]                       lane_diff;
  logic                             mismatch;
  logic                             done;
  logic                             passed;
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [AW-1:0]                    ram_raddr;
  logic [IW-1:0]                    rd_idx;
  logic [gplm_pkg::MODE_W-1:0]      mode_code;
  gplm_pkg::out_item_t              res;

  assign in_fire   = in_valid && !skid_valid_r;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign s_x = SAMPLE_BITS'(in_data.axis_x);
  assign s_y = SAMPLE_BITS'(in_data.axis_y);
  assign s_z = SAMPLE_BITS'(in_data.axis_z);

  assign is_sample    = (in_data.action == gplm_pkg::ACT_SAMPLE);
  assign idx_in_range = idx_r < LEN;
  assign idx_inc      = idx_r + 1'b1;
  assign cnt_inc      = (cnt_r < gplm_pkg::CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  // Pattern store: write during recording, prefetch the next entry to compare.
  assign ram_we    = in_fire && is_sample && (state_r == gplm_pkg::ST_REC) && idx_in_range;
  assign ram_waddr = idx_r[AW-1:0];
  assign rd_idx    = in_fire ? idx_nxt : idx_r;
  assign ram_raddr = (rd_idx < LEN) ? rd_idx[AW-1:0] : '0;

  gplm_ram #(
    .WIDTH (PW),
    .DEPTH (PATTERN_LEN)
  ) u_pattern_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({s_x, s_y, s_z}),
    .rd_addr (ram_raddr),
    .rd_data (stored)
  );

  gplm_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .stored    (stored[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .sample    (s_x),
    .tolerance (tol_r),
    .differs   (lane_diff[2])
  );

  gplm_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .stored    (stored[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .sample    (s_y),
    .tolerance (tol_r),
    .differs   (lane_diff[1])
  );

  gplm_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .stored    (stored[SAMPLE_BITS-1:0]),
    .sample    (s_z),
    .tolerance (tol_r),
    .differs   (lane_diff[0])
  );

  // Merge: a mismatch needs all three axes out of tolerance.
  assign mismatch = &lane_diff;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    failed_nxt = failed_r;
    done       = 1'b0;
    passed     = 1'b0;
    if (!is_sample) begin
      unique case (state_r)
        gplm_pkg::ST_UNSET: begin
          state_nxt = gplm_pkg::ST_REC;
          idx_nxt   = '0;
        end
        gplm_pkg::ST_LOCKED: begin
          state_nxt  = gplm_pkg::ST_CHECK;
          idx_nxt    = '0;
          cnt_nxt    = '0;
          failed_nxt = 1'b0;
        end
        gplm_pkg::ST_UNLOCKED: begin
          state_nxt = gplm_pkg::ST_LOCKED;
        end
        default: begin
        end
      endcase
    end else if (idx_in_range) begin
      unique case (state_r)
        gplm_pkg::ST_REC: begin
          idx_nxt = idx_inc;
          if (idx_inc >= LEN) begin
            state_nxt = gplm_pkg::ST_LOCKED;
          end
        end
        gplm_pkg::ST_CHECK: begin
          if (!failed_r && mismatch) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc > gplm_pkg::CNT_W'(limit_r)) begin
              failed_nxt = 1'b1;
            end
          end
          idx_nxt = idx_inc;
          if (idx_inc >= LEN) begin
            done      = 1'b1;
            passed    = !failed_nxt;
            state_nxt = failed_nxt ? gplm_pkg::ST_LOCKED : gplm_pkg::ST_UNLOCKED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (state_nxt)
      gplm_pkg::ST_UNSET:    mode_code = gplm_pkg::MODE_UNSET;
      gplm_pkg::ST_REC:      mode_code = gplm_pkg::MODE_REC;
      gplm_pkg::ST_LOCKED:   mode_code = gplm_pkg::MODE_LOCKED;
      gplm_pkg::ST_CHECK:    mode_code = gplm_pkg::MODE_CHECK;
      gplm_pkg::ST_UNLOCKED: mode_code = gplm_pkg::MODE_UNLOCKED;
      default:               mode_code = gplm_pkg::MODE_UNSET;
    endcase
  end

  always_comb begin
    res.mode           = mode_code;
    res.sample_count   = gplm_pkg::CNT_W'(idx_nxt);
    res.mismatch_total = cnt_nxt;
    res.attempt_done   = done;
    res.attempt_passed = passed;
  end

  always_comb begin
    tol_nxt   = tol_r;
    limit_nxt = limit_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == gplm_pkg::CFG_TOLERANCE) begin
        tol_nxt = cfg_wdata;
      end else if (cfg_index == gplm_pkg::CFG_MISMATCH_LIMIT) begin
        limit_nxt = cfg_wdata[gplm_pkg::LIMIT_W-1:0];
      end
    end
  end

  // Output register with one skid entry.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        out_data_nxt  = res;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gplm_pkg::ST_UNSET;
      idx_r        <= '0;
      cnt_r        <= '0;
      failed_r     <= 1'b0;
      tol_r        <= gplm_pkg::TOLERANCE_RST;
      limit_r      <= gplm_pkg::LIMIT_RST;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r  <= state_nxt;
        idx_r    <= idx_nxt;
        cnt_r    <= cnt_nxt;
        failed_r <= failed_nxt;
      end
      tol_r        <= tol_nxt;
      limit_r      <= limit_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_done_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.attempt_done) |->
      ((out_data_r.attempt_passed && out_data_r.mode == gplm_pkg::MODE_UNLOCKED) ||
       (!out_data_r.attempt_passed && out_data_r.mode == gplm_pkg::MODE_LOCKED)))
    else $error("attempt verdict disagrees with mode");

  a_failed_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && failed_r && is_sample && state_r == gplm_pkg::ST_CHECK) |=>
      (cnt_r == $past(cnt_r)))
    else $error("mismatch count moved after attempt failed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_free) |=> skid_valid_r)
    else $error("request accepted under stall not parked in skid entry");

endmodule

`default_nettype wire

// ----- rtl/gplm_ram.sv -----
`default_nettype none

module gplm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 30,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/gplm_axis_lane.sv -----
`default_nettype none

module gplm_axis_lane #(
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned CW = (SAMPLE_BITS > gplm_pkg::TOL_W) ? SAMPLE_BITS : gplm_pkg::TOL_W
) (
  input  wire logic [SAMPLE_BITS-1:0]     stored,
  input  wire logic [SAMPLE_BITS-1:0]     sample,
  input  wire logic [gplm_pkg::TOL_W-1:0] tolerance,
  output logic                            differs
);

  logic [SAMPLE_BITS-1:0] diff;

  always_comb begin
    if (stored > sample) begin
      diff = stored - sample;
    end else begin
      diff = sample - stored;
    end
    differs = CW'(diff) >= CW'(tolerance);
  end

endmodule

`default_nettype wire

// ----- dv/gplm_checker.sv -----
module gplm_checker
  import gplm_pkg::*;
#(
  parameter int unsigned PATTERN_LEN = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOL_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output logic [MODE_W-1:0]    mode_now
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [AXIS_W-1:0]  pat_x [PATTERN_LEN];
  logic [AXIS_W-1:0]  pat_y [PATTERN_LEN];
  logic [AXIS_W-1:0]  pat_z [PATTERN_LEN];
  logic [MODE_W-1:0]  mode_q;
  int unsigned        sample_idx;
  logic [CNT_W-1:0]   miss_q;
  logic               failed_q;
  logic [TOL_W-1:0]   tol_q;
  logic [LIMIT_W-1:0] lim_q;
  out_item_t          lock_status_q [$];

  function automatic bit far_apart(input logic [AXIS_W-1:0] a, input logic [AXIS_W-1:0] b);
    logic [AXIS_W-1:0] diff;
    diff = (a > b) ? a - b : b - a;
    return diff >= tol_q;
  endfunction

  task automatic advance_lock(input in_item_t req, output out_item_t res);
    logic done;
    logic passed;
    done   = 1'b0;
    passed = 1'b0;
    if (req.action == ACT_PRESS) begin
      case (mode_q)
        MODE_UNSET: begin
          mode_q     = MODE_REC;
          sample_idx = 0;
        end
        MODE_LOCKED: begin
          mode_q     = MODE_CHECK;
          sample_idx = 0;
          miss_q     = '0;
          failed_q   = 1'b0;
        end
        MODE_UNLOCKED: mode_q = MODE_LOCKED;
        default: ;
      endcase
    end else if (sample_idx < PATTERN_LEN) begin
      if (mode_q == MODE_REC) begin
        pat_x[sample_idx] = req.axis_x;
        pat_y[sample_idx] = req.axis_y;
        pat_z[sample_idx] = req.axis_z;
        sample_idx++;
        if (sample_idx >= PATTERN_LEN) mode_q = MODE_LOCKED;
      end else if (mode_q == MODE_CHECK) begin
        if (!failed_q && far_apart(pat_x[sample_idx], req.axis_x) &&
            far_apart(pat_y[sample_idx], req.axis_y) &&
            far_apart(pat_z[sample_idx], req.axis_z)) begin
          if (miss_q != CNT_MAX) miss_q++;
          if (miss_q > lim_q) failed_q = 1'b1;
        end
        sample_idx++;
        if (sample_idx >= PATTERN_LEN) begin
          done   = 1'b1;
          passed = !failed_q;
          mode_q = passed ? MODE_UNLOCKED : MODE_LOCKED;
        end
      end
    end
    res.mode           = mode_q;
    res.sample_count   = CNT_W'(sample_idx);
    res.mismatch_total = miss_q;
    res.attempt_done   = done;
    res.attempt_passed = passed;
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t next_res;
    if (!rst_n) begin
      fail_count = 0;
      mode_q     = MODE_UNSET;
      sample_idx = 0;
      miss_q     = '0;
      failed_q   = 1'b0;
      tol_q      = TOLERANCE_RST;
      lim_q      = LIMIT_RST;
      lock_status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (lock_status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected status mode=%0d cnt=%0d miss=%0d done=%0b pass=%0b",
                     $realtime, out_data.mode, out_data.sample_count,
                     out_data.mismatch_total, out_data.attempt_done, out_data.attempt_passed);
        end else begin
          want = lock_status_q.pop_front();
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: status mismatch exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                       $realtime, want.mode, want.sample_count, want.mismatch_total,
                       want.attempt_done, want.attempt_passed, out_data.mode,
                       out_data.sample_count, out_data.mismatch_total,
                       out_data.attempt_done, out_data.attempt_passed);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOLERANCE:      tol_q = cfg_wdata;
          CFG_MISMATCH_LIMIT: lim_q = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_lock(in_data, next_res);
        lock_status_q.push_back(next_res);
      end
    end
    pending  <= lock_status_q.size();
    mode_now <= mode_q;
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gplm_pkg::*;

  localparam int unsigned PATTERN_LEN     = 30;
  localparam int          ITEMS_PER_PHASE = 230;
  localparam int          NUM_PHASES      = 8;
  localparam int          CYCLE_LIMIT     = 600000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TOLERANCE;
  logic [TOL_W-1:0]     cfg_wdata = '0;
  int                   fail_count;
  int                   pending;
  logic [MODE_W-1:0]    mode_now;

  logic [AXIS_W-1:0] pat_x [PATTERN_LEN];
  logic [AXIS_W-1:0] pat_y [PATTERN_LEN];
  logic [AXIS_W-1:0] pat_z [PATTERN_LEN];
  int unsigned       cur_tol = 32'(TOLERANCE_RST);
  bit                in_burst = 1'b0;
  int                requests_sent = 0;
  int                cycle_count = 0;

  gesture_pattern_lock_matcher dut (.*);

  gplm_checker #(.PATTERN_LEN(PATTERN_LEN)) chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_drain
    int  n;
    bit  quiet;
    quiet = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      n = quiet ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // valid stays high after acceptance so back-to-back requests never toggle it
  task automatic send_item(input logic act, input logic [AXIS_W-1:0] x,
                           input logic [AXIS_W-1:0] y, input logic [AXIS_W-1:0] z);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, axis_x: x, axis_y: y, axis_z: z};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_config(input int unsigned tol, input int unsigned lim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_wdata <= TOL_W'(tol);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MISMATCH_LIMIT;
    cfg_wdata <= TOL_W'(lim);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_tol = tol;
  endtask

  // value at least (far) or below (near) the tolerance from pat_v when the range allows
  function automatic logic [AXIS_W-1:0] axis_value(input logic [AXIS_W-1:0] pat_v,
                                                   input bit far);
    int unsigned up_room;
    int unsigned dn_room;
    int unsigned max_off;
    int unsigned off;
    bit          exact;
    bit          up;
    up_room = 65535 - pat_v;
    dn_room = 32'(pat_v);
    exact   = ($urandom_range(0, 3) == 0);
    if (far) begin
      if (up_room < cur_tol && dn_room < cur_tol) return AXIS_W'($urandom);
      up = (up_room >= cur_tol) && (dn_room < cur_tol || $urandom_range(0, 1) == 1);
      off = exact ? cur_tol : $urandom_range(cur_tol, up ? up_room : dn_room);
      return up ? pat_v + AXIS_W'(off) : pat_v - AXIS_W'(off);
    end
    if (cur_tol == 0) return AXIS_W'($urandom);
    up      = ($urandom_range(0, 1) == 1);
    max_off = up ? up_room : dn_room;
    if (max_off > cur_tol - 1) max_off = cur_tol - 1;
    off = exact ? max_off : $urandom_range(0, max_off);
    return up ? pat_v + AXIS_W'(off) : pat_v - AXIS_W'(off);
  endfunction

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n)
      send_item($urandom_range(0, 1) ? ACT_SAMPLE : ACT_PRESS, AXIS_W'($urandom),
                AXIS_W'($urandom), AXIS_W'($urandom));
  endtask

  task automatic run_attempt();
    int          presses;
    int          cut;
    int          rate;
    int unsigned near_axes;
    presses = (mode_now == MODE_UNLOCKED) ? 2 : (mode_now == MODE_LOCKED) ? 1 : 0;
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PATTERN_LEN - 1) : PATTERN_LEN;
    rate = ($urandom_range(0, 1) == 1) ? $urandom_range(5, 35) : $urandom_range(0, 100);
    repeat (presses)
      send_item(ACT_PRESS, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
    for (int i = 0; i < cut; i++) begin
      // stray press mid-attempt is ignored by the block
      if ($urandom_range(0, 29) == 0)
        send_item(ACT_PRESS, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
      near_axes = ($urandom_range(0, 99) < rate) ? 0 : $urandom_range(1, 7);
      send_item(ACT_SAMPLE, axis_value(pat_x[i], !near_axes[0]),
                axis_value(pat_y[i], !near_axes[1]), axis_value(pat_z[i], !near_axes[2]));
    end
  endtask

  initial begin : stimulus
    int unsigned tol_tbl [6];
    int unsigned lim_tbl [6];
    int          phase_start;
    tol_tbl = '{0, 65535, 1, 2000, 300, 40000};
    lim_tbl = '{0, 31, 0, 5, 3, 29};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored sample, start press, ignored press, extreme-value recording
    send_item(ACT_SAMPLE, '1, '1, '1);
    send_item(ACT_PRESS, '0, '0, '0);
    send_item(ACT_PRESS, '1, '1, '1);
    for (int i = 0; i < PATTERN_LEN; i++) begin
      case (i)
        0: begin
          pat_x[i] = '0;
          pat_y[i] = '0;
          pat_z[i] = '0;
        end
        1: begin
          pat_x[i] = '1;
          pat_y[i] = '1;
          pat_z[i] = '1;
        end
        2: begin
          pat_x[i] = '0;
          pat_y[i] = '1;
          pat_z[i] = 16'h8000;
        end
        3: begin
          pat_x[i] = '1;
          pat_y[i] = '0;
          pat_z[i] = 16'h7fff;
        end
        default: begin
          pat_x[i] = AXIS_W'($urandom);
          pat_y[i] = AXIS_W'($urandom);
          pat_z[i] = AXIS_W'($urandom);
        end
      endcase
      send_item(ACT_SAMPLE, pat_x[i], pat_y[i], pat_z[i]);
    end
    send_item(ACT_SAMPLE, 16'h1234, 16'hedcb, 16'h5a5a);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      wait_drained();
      if (p < 6) write_config(tol_tbl[p], lim_tbl[p]);
      else write_config($urandom_range(0, 65535), $urandom_range(0, 31));
      phase_start = requests_sent;
      while (requests_sent - phase_start < ITEMS_PER_PHASE) begin
        settle();
        if ($urandom_range(0, 14) == 0) wait_drained();
        in_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) send_noise();
        else run_attempt();
      end
    end

    settle();
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
